FILE: rtl/rtm_pkg.sv
// Shared constants, codes, types and a key nibble helper for the radix-16 trie identifier map.
package rtm_pkg;

	localparam int NODE_COUNT_DEF  = 1024;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FANOUT          = 16;
	localparam int NIB_W           = 4;
	localparam logic [2:0] LEAF_DEPTH = 3'd7;

	typedef enum logic [1:0] {
		FN_SET   = 2'd0,
		FN_GET   = 2'd1,
		FN_FIRST = 2'd2,
		FN_NEXT  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_NO_SPACE  = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_WALK_RD,
		S_WALK_EV,
		S_SET_DEC,
		S_LEAF_CLR,
		S_PRUNE_RD,
		S_PRUNE_EV,
		S_PRUNE_UP,
		S_ALLOC,
		S_ALLOC_WAIT,
		S_NEWCLR,
		S_LINK,
		S_LEAF_WR,
		S_FIND_RD,
		S_FIND_EV,
		S_FIND_NEXT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic alloc;
		logic free;
	} pool_req_t;

	// Nibble of a key used at a given trie depth, most significant first.
	function automatic logic [3:0] key_nib(input logic [31:0] k, input logic [2:0] d);
		logic [7:0][3:0] kk;
		kk = k;
		return kk[~d];
	endfunction

endpackage

FILE: rtl/rtm_slot_mem.sv
// Node slot memory: one write port and one registered read port.
module rtm_slot_mem #(
	parameter int ADDR_W = 14,
	parameter int SLOT_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [SLOT_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [SLOT_W-1:0] rdata
);

	logic [SLOT_W-1:0] mem [2**ADDR_W];
	logic [SLOT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rtm_node_pool.sv
// Node pool: hands out fresh node indices and recycles freed ones through a stack.
module rtm_node_pool #(
	parameter int NODE_COUNT = rtm_pkg::NODE_COUNT_DEF,
	localparam int NODE_W = $clog2(NODE_COUNT),
	localparam int CNT_W  = $clog2(NODE_COUNT + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rtm_pkg::pool_req_t req,
	input  logic [NODE_W-1:0] free_node,
	output logic [NODE_W-1:0] alloc_node,
	output logic [CNT_W-1:0]  free_count
);

	logic [NODE_W-1:0] stk [NODE_COUNT];
	logic [NODE_W-1:0] sp_q;
	logic [NODE_W-1:0] fresh_q;
	logic [CNT_W-1:0]  count_q;
	logic [NODE_W-1:0] node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			fresh_q <= NODE_W'(1);
			count_q <= CNT_W'(NODE_COUNT - 1);
		end else if (req.alloc) begin
			count_q <= count_q - 1'b1;
			if (sp_q != '0) begin
				sp_q <= sp_q - 1'b1;
			end else begin
				fresh_q <= fresh_q + 1'b1;
			end
		end else if (req.free) begin
			count_q <= count_q + 1'b1;
			sp_q    <= sp_q + 1'b1;
		end
	end

	// Recycled nodes are used first; untouched nodes are taken in index order.
	always_ff @(posedge clk) begin
		if (req.alloc) begin
			if (sp_q != '0) begin
				node_q <= stk[NODE_W'(sp_q - 1'b1)];
			end else begin
				node_q <= fresh_q;
			end
		end else if (req.free) begin
			stk[sp_q] <= free_node;
		end
	end

	assign alloc_node = node_q;
	assign free_count = count_q;

endmodule

FILE: rtl/radix16_trie_id_map.sv
// Each trie slot visit is a read state and an evaluate state on the single read port of the node slot memory;
// a new node costs 16 clearing writes and a pruning step a 16-slot scan.
// Throughput: one operation at a time; the input stalls until the result is registered.
// Reset: asynchronous; afterwards a pass over its 16 slots clears the root node before the first transfer.
// Top level: sequencer that walks, grows, prunes and searches the trie.
module radix16_trie_id_map #(
	parameter int NODE_COUNT  = rtm_pkg::NODE_COUNT_DEF,
	parameter int VALUE_WIDTH = rtm_pkg::VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_key,
	output logic [31:0] read_value
);

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int SLOT_W = (VALUE_WIDTH > NODE_W) ? VALUE_WIDTH : NODE_W;
	localparam int ADDR_W = NODE_W + rtm_pkg::NIB_W;
	localparam int CNT_W  = $clog2(NODE_COUNT + 1);

	rtm_pkg::state_t state_q, state_d;

	logic [1:0]          func_q;
	logic [31:0]         key_q;
	logic [SLOT_W-1:0]   val_q;
	logic [2:0]          depth_q;
	logic [NODE_W-1:0]   path_q [8];
	logic [3:0]          cnt_q;
	logic [7:0][3:0]     wk_q;
	logic [31:0]         start_q;
	logic                tight_q;
	logic [31:0]         cursor_q;
	logic [1:0]          res_status_q;
	logic [31:0]         res_fk_q;
	logic [31:0]         res_rv_q;
	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [31:0]         out_fk_q;
	logic [31:0]         out_rv_q;

	logic                mem_we, mem_re;
	logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
	logic [SLOT_W-1:0]   mem_wdata, rdata;
	rtm_pkg::pool_req_t  pool_req;
	logic [NODE_W-1:0]   pool_node;
	logic [CNT_W-1:0]    free_count;

	logic [63:0]         val64, rd64;
	logic [SLOT_W-1:0]   val_slot;
	logic                rd_nz;
	logic [NODE_W-1:0]   child;
	logic [2:0]          depth_up;
	logic [2:0]          missing;
	logic                out_free;
	logic [3:0]          wk_nib;

	assign val64    = 64'(value);
	assign val_slot = SLOT_W'(val64[VALUE_WIDTH-1:0]);
	assign rd64     = 64'(rdata);
	assign rd_nz    = |rdata;
	assign child    = rdata[NODE_W-1:0];
	assign depth_up = depth_q + 3'd1;
	assign missing  = ~depth_q;
	assign out_free = !out_valid_q || !out_stall;
	assign wk_nib   = wk_q[~depth_q];

	rtm_slot_mem #(
		.ADDR_W(ADDR_W),
		.SLOT_W(SLOT_W)
	) u_slots (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	rtm_node_pool #(
		.NODE_COUNT(NODE_COUNT)
	) u_pool (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (pool_req),
		.free_node (path_q[depth_q]),
		.alloc_node(pool_node),
		.free_count(free_count)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rtm_pkg::S_CLR: begin
				if (cnt_q == 4'hf) state_d = rtm_pkg::S_IDLE;
			end
			rtm_pkg::S_IDLE: begin
				if (in_valid) begin
					case (func)
						rtm_pkg::FN_SET, rtm_pkg::FN_GET: state_d = rtm_pkg::S_WALK_RD;
						rtm_pkg::FN_FIRST: state_d = rtm_pkg::S_FIND_RD;
						default: state_d = (cursor_q == 32'hffff_ffff) ?
							rtm_pkg::S_FIN : rtm_pkg::S_FIND_RD;
					endcase
				end
			end
			rtm_pkg::S_WALK_RD: state_d = rtm_pkg::S_WALK_EV;
			rtm_pkg::S_WALK_EV: begin
				if (depth_q == rtm_pkg::LEAF_DEPTH) begin
					state_d = rtm_pkg::S_FIN;
				end else if (!rd_nz) begin
					state_d = (func_q == rtm_pkg::FN_GET) ? rtm_pkg::S_FIN : rtm_pkg::S_SET_DEC;
				end else if (func_q == rtm_pkg::FN_SET && depth_up == rtm_pkg::LEAF_DEPTH) begin
					state_d = rtm_pkg::S_SET_DEC;
				end else begin
					state_d = rtm_pkg::S_WALK_RD;
				end
			end
			rtm_pkg::S_SET_DEC: begin
				if (val_q == '0) begin
					state_d = (depth_q != rtm_pkg::LEAF_DEPTH) ? rtm_pkg::S_FIN :
						rtm_pkg::S_LEAF_CLR;
				end else if (CNT_W'(missing) > free_count) begin
					state_d = rtm_pkg::S_FIN;
				end else if (depth_q == rtm_pkg::LEAF_DEPTH) begin
					state_d = rtm_pkg::S_LEAF_WR;
				end else begin
					state_d = rtm_pkg::S_ALLOC;
				end
			end
			rtm_pkg::S_LEAF_CLR: state_d = rtm_pkg::S_PRUNE_RD;
			rtm_pkg::S_PRUNE_RD: state_d = rtm_pkg::S_PRUNE_EV;
			rtm_pkg::S_PRUNE_EV: begin
				if (rd_nz) state_d = rtm_pkg::S_FIN;
				else if (cnt_q == 4'hf) state_d = rtm_pkg::S_PRUNE_UP;
				else state_d = rtm_pkg::S_PRUNE_RD;
			end
			rtm_pkg::S_PRUNE_UP: begin
				state_d = (depth_q == 3'd1) ? rtm_pkg::S_FIN : rtm_pkg::S_PRUNE_RD;
			end
			rtm_pkg::S_ALLOC: state_d = rtm_pkg::S_ALLOC_WAIT;
			rtm_pkg::S_ALLOC_WAIT: state_d = rtm_pkg::S_NEWCLR;
			rtm_pkg::S_NEWCLR: begin
				if (cnt_q == 4'hf) state_d = rtm_pkg::S_LINK;
			end
			rtm_pkg::S_LINK: begin
				state_d = (depth_up == rtm_pkg::LEAF_DEPTH) ? rtm_pkg::S_LEAF_WR :
					rtm_pkg::S_ALLOC;
			end
			rtm_pkg::S_LEAF_WR: state_d = rtm_pkg::S_FIN;
			rtm_pkg::S_FIND_RD: state_d = rtm_pkg::S_FIND_EV;
			rtm_pkg::S_FIND_EV: begin
				if (rd_nz && depth_q == rtm_pkg::LEAF_DEPTH) state_d = rtm_pkg::S_FIN;
				else if (rd_nz) state_d = rtm_pkg::S_FIND_RD;
				else state_d = rtm_pkg::S_FIND_NEXT;
			end
			rtm_pkg::S_FIND_NEXT: begin
				if (wk_nib != 4'hf) state_d = rtm_pkg::S_FIND_RD;
				else if (depth_q == 3'd0) state_d = rtm_pkg::S_FIN;
			end
			rtm_pkg::S_FIN: begin
				if (out_free) state_d = rtm_pkg::S_IDLE;
			end
			default: state_d = rtm_pkg::S_IDLE;
		endcase
	end

	// Memory and pool controls.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		pool_req  = '0;
		case (state_q)
			rtm_pkg::S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {NODE_W'(0), cnt_q};
			end
			rtm_pkg::S_WALK_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {path_q[depth_q], rtm_pkg::key_nib(key_q, depth_q)};
			end
			rtm_pkg::S_LEAF_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = {path_q[depth_q], rtm_pkg::key_nib(key_q, depth_q)};
			end
			rtm_pkg::S_PRUNE_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {path_q[depth_q], cnt_q};
			end
			rtm_pkg::S_PRUNE_UP: begin
				mem_we        = 1'b1;
				mem_waddr     = {path_q[depth_q - 3'd1],
					rtm_pkg::key_nib(key_q, depth_q - 3'd1)};
				pool_req.free = 1'b1;
			end
			rtm_pkg::S_ALLOC: pool_req.alloc = 1'b1;
			rtm_pkg::S_NEWCLR: begin
				mem_we    = 1'b1;
				mem_waddr = {path_q[depth_up], cnt_q};
			end
			rtm_pkg::S_LINK: begin
				mem_we    = 1'b1;
				mem_waddr = {path_q[depth_q], rtm_pkg::key_nib(key_q, depth_q)};
				mem_wdata = SLOT_W'(path_q[depth_up]);
			end
			rtm_pkg::S_LEAF_WR: begin
				mem_we    = 1'b1;
				mem_waddr = {path_q[depth_q], rtm_pkg::key_nib(key_q, depth_q)};
				mem_wdata = val_q;
			end
			rtm_pkg::S_FIND_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {path_q[depth_q], wk_nib};
			end
			default: ;
		endcase
	end

	// Control state and walk registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rtm_pkg::S_CLR;
			cnt_q        <= '0;
			depth_q      <= '0;
			cursor_q     <= '0;
			tight_q      <= 1'b0;
			func_q       <= '0;
			res_status_q <= rtm_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			case (state_q)
				rtm_pkg::S_CLR: cnt_q <= cnt_q + 4'd1;
				rtm_pkg::S_IDLE: begin
					if (in_valid) begin
						func_q       <= func;
						depth_q      <= '0;
						tight_q      <= 1'b1;
						if (func == rtm_pkg::FN_NEXT && cursor_q == 32'hffff_ffff) begin
							res_status_q <= rtm_pkg::STAT_NOT_FOUND;
							cursor_q     <= '0;
						end else begin
							res_status_q <= rtm_pkg::STAT_OK;
						end
					end
				end
				rtm_pkg::S_WALK_EV: begin
					if (depth_q != rtm_pkg::LEAF_DEPTH && rd_nz) depth_q <= depth_up;
				end
				rtm_pkg::S_SET_DEC: begin
					if (val_q == '0) begin
						if (depth_q != rtm_pkg::LEAF_DEPTH)
							res_status_q <= rtm_pkg::STAT_NOT_FOUND;
					end else if (CNT_W'(missing) > free_count) begin
						res_status_q <= rtm_pkg::STAT_NO_SPACE;
					end
				end
				rtm_pkg::S_LEAF_CLR: cnt_q <= '0;
				rtm_pkg::S_PRUNE_EV: cnt_q <= cnt_q + 4'd1;
				rtm_pkg::S_PRUNE_UP: begin
					depth_q <= depth_q - 3'd1;
					cnt_q   <= '0;
				end
				rtm_pkg::S_ALLOC_WAIT: cnt_q <= '0;
				rtm_pkg::S_NEWCLR: cnt_q <= cnt_q + 4'd1;
				rtm_pkg::S_LINK: depth_q <= depth_up;
				rtm_pkg::S_FIND_EV: begin
					if (rd_nz && depth_q == rtm_pkg::LEAF_DEPTH) cursor_q <= wk_q;
					else if (rd_nz) depth_q <= depth_up;
				end
				rtm_pkg::S_FIND_NEXT: begin
					// Any step sideways leaves the lower bound behind for good.
					tight_q <= 1'b0;
					if (wk_nib == 4'hf) begin
						if (depth_q == 3'd0) begin
							res_status_q <= rtm_pkg::STAT_NOT_FOUND;
							if (func_q == rtm_pkg::FN_NEXT) cursor_q <= '0;
						end else begin
							depth_q <= depth_q - 3'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the walk.
	always_ff @(posedge clk) begin
		case (state_q)
			rtm_pkg::S_IDLE: begin
				key_q     <= key;
				val_q     <= val_slot;
				path_q[0] <= '0;
				res_fk_q  <= '0;
				res_rv_q  <= '0;
				if (func == rtm_pkg::FN_NEXT) begin
					start_q <= cursor_q + 32'd1;
					wk_q    <= cursor_q + 32'd1;
				end else begin
					start_q <= '0;
					wk_q    <= '0;
				end
			end
			rtm_pkg::S_WALK_EV: begin
				if (depth_q == rtm_pkg::LEAF_DEPTH) res_rv_q <= rd64[31:0];
				else if (rd_nz) path_q[depth_up] <= child;
			end
			rtm_pkg::S_ALLOC_WAIT: path_q[depth_up] <= pool_node;
			rtm_pkg::S_FIND_EV: begin
				if (rd_nz && depth_q == rtm_pkg::LEAF_DEPTH) begin
					res_fk_q <= wk_q;
				end else if (rd_nz) begin
					path_q[depth_up] <= child;
					wk_q[~depth_up]  <= tight_q ? rtm_pkg::key_nib(start_q, depth_up) : 4'h0;
				end
			end
			rtm_pkg::S_FIND_NEXT: begin
				if (wk_nib != 4'hf) wk_q[~depth_q] <= wk_nib + 4'd1;
			end
			default: ;
		endcase
	end

	// Output register: a finished result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == rtm_pkg::S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rtm_pkg::S_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_fk_q     <= res_fk_q;
			out_rv_q     <= res_rv_q;
		end
	end

	assign in_stall   = (state_q != rtm_pkg::S_IDLE);
	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign found_key  = out_fk_q;
	assign read_value = out_rv_q;

endmodule

FILE: test/radix16_trie_id_map_tb.sv
// Self-checking testbench for the radix-16 trie identifier map.
`timescale 1ns / 100ps

module radix16_trie_id_map_tb;

	localparam int NODES = 1024;
	localparam int MAX_CYCLES = 80000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic [31:0] key;
	logic [31:0] value;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [31:0] found_key;
	logic [31:0] read_value;

	radix16_trie_id_map i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .key(key), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found_key(found_key), .read_value(read_value)
	);

	typedef struct packed {
		logic [1:0] st;
		logic [31:0] fk;
		logic [31:0] rv;
	} answer_t;

	// Behavioural trie: slots of every node, free stack and the cursor.
	logic [31:0] trie [NODES*rtm_pkg::FANOUT];
	int unsigned spare [NODES];
	int unsigned spare_cnt;
	logic [31:0] cursor;

	answer_t pending_answers [$];
	logic [31:0] known_keys [$];
	int errors;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	always @(posedge clk) begin
		if (cycles == MAX_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [3:0] nib_at(logic [31:0] k, int d);
		return k[28-4*d +: 4];
	endfunction

	function automatic void trie_reset();
		for (int i = 0; i < NODES*rtm_pkg::FANOUT; i++) trie[i] = '0;
		for (int i = 1; i < NODES; i++) spare[i-1] = i;
		spare_cnt = NODES - 1;
		cursor = '0;
	endfunction

	function automatic bit search_ge(int unsigned nd, int d, logic [31:0] pre, bit tight,
			logic [31:0] start, output logic [31:0] res);
		int lo;
		logic [31:0] k;
		lo = tight ? nib_at(start, d) : 0;
		for (int i = lo; i < rtm_pkg::FANOUT; i++) begin
			if (trie[nd*rtm_pkg::FANOUT+i] == 0) continue;
			k = pre | (32'(i) << (28 - 4*d));
			if (d == 7) begin
				res = k;
				return 1;
			end
			if (trie[nd*rtm_pkg::FANOUT+i] < NODES &&
					search_ge(trie[nd*rtm_pkg::FANOUT+i], d+1, k, tight && i == lo, start, res))
				return 1;
		end
		return 0;
	endfunction

	function automatic logic [1:0] trie_set(logic [31:0] k, logic [31:0] v);
		int unsigned path [8];
		int d;
		int unsigned nd, n, c;
		bit empty;
		d = 0;
		nd = 0;
		path[0] = 0;
		while (d < 7) begin
			c = trie[nd*rtm_pkg::FANOUT+nib_at(k, d)];
			if (c == 0 || c >= NODES) break;
			nd = c;
			d++;
			path[d] = nd;
		end
		if (v == 0) begin
			if (d != 7) return rtm_pkg::STAT_NOT_FOUND;
			trie[nd*rtm_pkg::FANOUT+nib_at(k, 7)] = '0;
			n = nd;
			while (d > 0) begin
				empty = 1;
				for (int i = 0; i < rtm_pkg::FANOUT; i++)
					if (trie[n*rtm_pkg::FANOUT+i] != 0) empty = 0;
				if (!empty) break;
				trie[path[d-1]*rtm_pkg::FANOUT+nib_at(k, d-1)] = '0;
				spare[spare_cnt] = n;
				spare_cnt++;
				n = path[d-1];
				d--;
			end
			return rtm_pkg::STAT_OK;
		end
		if (7 - d > spare_cnt) return rtm_pkg::STAT_NO_SPACE;
		while (d < 7) begin
			spare_cnt--;
			c = spare[spare_cnt];
			for (int i = 0; i < rtm_pkg::FANOUT; i++) trie[c*rtm_pkg::FANOUT+i] = '0;
			trie[nd*rtm_pkg::FANOUT+nib_at(k, d)] = c;
			nd = c;
			d++;
		end
		trie[nd*rtm_pkg::FANOUT+nib_at(k, 7)] = v;
		return rtm_pkg::STAT_OK;
	endfunction

	function automatic answer_t predict_answer(logic [1:0] f, logic [31:0] k, logic [31:0] v);
		answer_t a;
		int unsigned nd;
		logic [31:0] hit;
		a = '0;
		case (f)
			rtm_pkg::FN_SET: a.st = trie_set(k, v);
			rtm_pkg::FN_GET: begin
				nd = 0;
				for (int d = 0; d < 7; d++) begin
					if (nd == NODES) break;
					nd = trie[nd*rtm_pkg::FANOUT+nib_at(k, d)];
					if (nd == 0 || nd >= NODES) nd = NODES;
				end
				if (nd != NODES) a.rv = trie[nd*rtm_pkg::FANOUT+nib_at(k, 7)];
			end
			rtm_pkg::FN_FIRST: begin
				if (search_ge(0, 0, '0, 1, '0, hit)) begin
					cursor = hit;
					a.fk = hit;
				end else a.st = rtm_pkg::STAT_NOT_FOUND;
			end
			default: begin
				if (cursor != 32'hffffffff && search_ge(0, 0, '0, 1, cursor + 1, hit)) begin
					cursor = hit;
					a.fk = hit;
				end else begin
					cursor = '0;
					a.st = rtm_pkg::STAT_NOT_FOUND;
				end
			end
		endcase
		return a;
	endfunction

	// Sends one operation, waiting a random number of cycles first.
	task automatic send_op(logic [1:0] f, logic [31:0] k, logic [31:0] v);
		int unsigned gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		key <= k;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_answers.push_back(predict_answer(f, k, v));
		if (f == rtm_pkg::FN_SET && v != 0) known_keys.push_back(k);
	endtask

	always @(posedge clk) begin
		answer_t exp_a;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				exp_a = pending_answers.pop_front();
				if (status !== exp_a.st) begin
					$error("status: expected %0d, actual %0d", exp_a.st, status);
					errors++;
				end
				if (found_key !== exp_a.fk) begin
					$error("found_key: expected %h, actual %h", exp_a.fk, found_key);
					errors++;
				end
				if (read_value !== exp_a.rv) begin
					$error("read_value: expected %h, actual %h", exp_a.rv, read_value);
					errors++;
				end
			end
		end
	end

	// Receiver stall: held for a random stretch, sometimes not at all.
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			n = $urandom_range(0, 11);
			if ($urandom_range(0, 2) == 0) begin
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end else begin
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic logic [31:0] pick_key();
		if (known_keys.size() != 0 && $urandom_range(0, 1))
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		return $urandom_range(0, 3) == 0 ? $urandom() : {4'($urandom_range(0, 3)), 20'h0,
			4'($urandom_range(0, 15)), 4'h0} ^ {28'h0, 4'($urandom())};
	endfunction

	task automatic test_directed();
		send_op(rtm_pkg::FN_FIRST, '0, '0);
		send_op(rtm_pkg::FN_NEXT, '0, '0);
		send_op(rtm_pkg::FN_SET, 32'h5, '0);
		send_op(rtm_pkg::FN_SET, '0, 32'h1);
		send_op(rtm_pkg::FN_SET, 32'hffffffff, 32'hffffffff);
		send_op(rtm_pkg::FN_GET, 32'hffffffff, '0);
		send_op(rtm_pkg::FN_GET, 32'h12345678, '0);
		send_op(rtm_pkg::FN_NEXT, '0, '0);
		send_op(rtm_pkg::FN_FIRST, '0, '0);
		send_op(rtm_pkg::FN_NEXT, '0, '0);
		send_op(rtm_pkg::FN_NEXT, '0, '0);
		send_op(rtm_pkg::FN_NEXT, '0, '0);
		send_op(rtm_pkg::FN_SET, 32'hfffffff0, 32'h5a5a5a5a);
		send_op(rtm_pkg::FN_SET, 32'hffffff00, '0);
		send_op(rtm_pkg::FN_SET, 32'hfffffff1, '0);
		send_op(rtm_pkg::FN_FIRST, '0, '0);
		send_op(rtm_pkg::FN_SET, '0, '0);
		send_op(rtm_pkg::FN_NEXT, '0, '0);
		send_op(rtm_pkg::FN_SET, 32'hfffffff0, '0);
		send_op(rtm_pkg::FN_SET, 32'hffffffff, '0);
		send_op(rtm_pkg::FN_FIRST, '0, '0);
		send_op(rtm_pkg::FN_GET, '0, '0);
	endtask

	// Sets 200 scattered keys to drive the pool towards no_space, then frees them.
	task automatic test_pool_exhaustion();
		logic [31:0] k;
		logic [31:0] used [$];
		for (int i = 0; i < 200; i++) begin
			k = {8'(i), 16'($urandom_range(0, 255)), 8'(i) ^ 8'h5a} ^ $urandom();
			used.push_back(k);
			send_op(rtm_pkg::FN_SET, k, $urandom() | 32'h1);
		end
		send_op(rtm_pkg::FN_SET, 32'hdeadbeef, 32'h7);
		send_op(rtm_pkg::FN_FIRST, '0, '0);
		for (int i = 0; i < 40; i++) send_op(rtm_pkg::FN_NEXT, '0, '0);
		foreach (used[i]) send_op(rtm_pkg::FN_SET, used[i], '0);
		send_op(rtm_pkg::FN_FIRST, '0, '0);
	endtask

	task automatic test_random_ops();
		logic [1:0] f;
		logic [31:0] v;
		for (int i = 0; i < 900; i++) begin
			f = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 2) == 0) f = rtm_pkg::FN_SET;
			v = $urandom_range(0, 3) == 0 ? '0 : $urandom();
			send_op(f, pick_key(), v);
		end
		while (known_keys.size() != 0) send_op(rtm_pkg::FN_SET, known_keys.pop_back(), '0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = rtm_pkg::FN_GET;
		key = '0;
		value = '0;
		errors = 0;
		cycles = 0;
		trie_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_exhaustion();
		test_random_ops();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
